// ===== sv/fpk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpk_pkg: shared types, constants and helpers of the fresnel phase kernel
// cell payload types, cordic constants and the angle pre/post steps
// ----------------------------------------------------------------------------
package fpk_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int SHIFT_W      = 6;
  localparam int XDIV_STEPS   = 128;
  localparam int EDIV_STEPS   = 158;
  localparam int SQRT_STEPS   = 64;
  localparam int IN_W         = 288;
  localparam int OUT_W        = 64;

  localparam logic signed [63:0] CORDIC_X0      = 64'sd2608131496 <<< 30;
  localparam logic signed [63:0] PI_Q30         = 64'sd3373259426;
  localparam logic [63:0]        QUARTER_PI_Q61 = 64'h1921_FB54_442D_1846;
  localparam logic [98:0]        XI_CAP         = 99'd1 << 95;
  localparam logic [98:0]        ETA_CAP        = 99'd1 << 97;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic [127:0] num;
    logic [95:0]  rem;
    logic [98:0]  quo;
    logic         ovf;
    logic [95:0]  den;
  } div_t;

  typedef struct packed {
    logic [127:0] v;
    logic [65:0]  rem;
    logic [63:0]  root;
  } sqrt_t;

  // atan(2^-i) in q61, taylor series in q63 with truncated terms
  function automatic logic [63:0] atan_q61(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    int unsigned k;
    sum = '0;
    if (i == 0) return QUARTER_PI_Q61;
    for (k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 63) begin
        term = (64'h8000_0000_0000_0000 >> e) / 64'(2 * k + 1);
        if (k[0] == 1'b0) sum = sum + term;
        else sum = sum - term;
      end
    end
    return (sum + 64'd2) >> 2;
  endfunction

  // nearest quarter turn plus residual angle in radians q61
  function automatic cordic_t cos_prep(input logic [31:0] a);
    cordic_t c;
    logic [31:0] biased;
    logic [31:0] rest;
    biased = a + 32'h2000_0000;
    c.quad = biased[31:30];
    rest   = a - {c.quad, 30'd0};
    c.x    = CORDIC_X0;
    c.y    = '0;
    c.z    = 64'(signed'(rest)) * PI_Q30;
    return c;
  endfunction

  // quadrant select, round to q30 and clamp to [-1, 1]
  function automatic logic signed [31:0] cos_post(input cordic_t c);
    logic signed [63:0] s;
    logic signed [63:0] r;
    case (c.quad)
      2'd0:    s = c.x;
      2'd1:    s = -c.y;
      2'd2:    s = -c.x;
      default: s = c.y;
    endcase
    r = (s + 64'sd2147483648) >>> 32;
    if (r > 64'sd1073741824) r = 64'sd1073741824;
    if (r < -64'sd1073741824) r = -64'sd1073741824;
    return r[31:0];
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] c);
    logic [31:0] m;
    m = c[31] ? 32'(-c) : 32'(c);
    return m[30:0];
  endfunction

endpackage

// ===== sv/fresnel_phase_kernel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_phase_kernel_top: fresnel phase psi of one ring occultation point
// psi = kD * (sqrt(1 + eta - 2 xi) + xi - 1), fixed point, saturated
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output buffer has room; every cell of every
//   chain hands its item on in each such cycle, so the chain lengths add latency only
// a two-entry output buffer decouples the sides; in_tready drops only when
//   both entries hold undelivered results
// reset: synchronous, clears the valid pipeline and the output buffer
module fresnel_phase_kernel_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // wave_distance[47:0] radius[95:48] ref_radius[143:96] azimuth[175:144]
  // ref_azimuth[207:176] opening_angle[239:208] distance[287:240]
  input  logic [fpk_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // phase[63:0]
  output logic [fpk_pkg::OUT_W-1:0]  out_tdata,
  // domain_error[0]
  output logic [0:0]                 out_tuser
);
  import fpk_pkg::*;

  // pipeline stage positions
  localparam int ST_E  = CORDIC_STEPS + 6;
  localparam int ST_F  = ST_E + EDIV_STEPS + 1;
  localparam int ST_J  = ST_F + SQRT_STEPS + 3;
  localparam int DEPTH = ST_J + 1;
  localparam int XLAG  = EDIV_STEPS - XDIV_STEPS;

  typedef struct packed {
    logic [47:0] kd;
    logic [47:0] rr;
    logic [47:0] r0;
    logic [47:0] dd;
  } geo_t;

  typedef struct packed {
    logic [47:0] kd;
    logic        xneg;
    logic        zero;
  } dside_t;

  typedef struct packed {
    logic [47:0] kd;
    logic        xneg;
    logic        err;
    logic [75:0] x40;
  } sside_t;

  typedef struct packed {
    logic [63:0] phase;
    logic        err;
  } res_t;

  // input fields
  logic [47:0] in_wave_distance;
  logic [47:0] in_radius;
  logic [47:0] in_ref_radius;
  logic [31:0] in_azimuth;
  logic [31:0] in_ref_azimuth;
  logic [31:0] in_opening_angle;
  logic [47:0] in_distance;

  assign in_wave_distance = in_tdata[47:0];
  assign in_radius        = in_tdata[95:48];
  assign in_ref_radius    = in_tdata[143:96];
  assign in_azimuth       = in_tdata[175:144];
  assign in_ref_azimuth   = in_tdata[207:176];
  assign in_opening_angle = in_tdata[239:208];
  assign in_distance      = in_tdata[287:240];

  // flow control: the whole chain moves while the output buffer has room
  logic             en;
  logic [1:0]       cnt_r;
  logic [DEPTH-1:0] vld_r;
  logic             push;
  logic             pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && vld_r[DEPTH-1];
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- cosines
  // four cordic chains: opening angle, azimuth, ref azimuth, their difference
  cordic_t c0_r [4];
  cordic_t cw   [4][CORDIC_STEPS];
  geo_t    geo_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r[0]  <= cos_prep(in_opening_angle);
      c0_r[1]  <= cos_prep(in_azimuth);
      c0_r[2]  <= cos_prep(in_ref_azimuth);
      c0_r[3]  <= cos_prep(in_azimuth - in_ref_azimuth);
      geo_r[0] <= '{kd: in_wave_distance, rr: in_radius, r0: in_ref_radius,
                    dd: in_distance};
      for (int i = 1; i <= CORDIC_STEPS; i++) geo_r[i] <= geo_r[i-1];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_ang
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      if (i == 0) begin : g_head
        fpk_cordic_cell u_cell (
          .clk   (clk),
          .en    (en),
          .shift (SHIFT_W'(i)),
          .atan  (atan_q61(i)),
          .d_in  (c0_r[j]),
          .d_out (cw[j][i])
        );
      end else begin : g_body
        fpk_cordic_cell u_cell (
          .clk   (clk),
          .en    (en),
          .shift (SHIFT_W'(i)),
          .atan  (atan_q61(i)),
          .d_in  (cw[j][i-1]),
          .d_out (cw[j][i])
        );
      end
    end
  end

  // ------------------------------------------------------- products and sums
  logic signed [31:0] p_cb_r, p_cp_r, p_cp0_r, p_cd_r;
  geo_t               p_geo_r;

  logic [78:0] a_a1_r, a_a2_r;
  logic        a_n1_r, a_n2_r, a_cbn_r, a_cdp_r;
  logic [30:0] a_cbm_r, a_cdm_r;
  logic [71:0] a_rrl_r, a_rrh_r, a_r0l_r, a_r0h_r, a_rxl_r, a_rxh_r, a_ddl_r, a_ddh_r;
  logic [47:0] a_kd_r, a_dd_r;

  logic [79:0] b_am_r;
  logic        b_xneg_r, b_cdp_r;
  logic [30:0] b_cbm_r, b_cdm_r;
  logic [95:0] b_rr2_r, b_r02_r, b_rx_r, b_dd2_r;
  logic [47:0] b_kd_r, b_dd_r;

  logic [70:0]  c_xl_r, c_xh_r;
  logic [127:0] c_s1_r;
  logic [79:0]  c_pl_r, c_ph_r;
  logic         c_xneg_r, c_cdp_r;
  logic [95:0]  c_dd2_r;
  logic [47:0]  c_kd_r, c_dd_r;

  logic [127:0] d_xnum_r, d_p2_r, d_s1_r;
  logic         d_xneg_r, d_cdp_r;
  logic [95:0]  d_dd2_r;
  logic [47:0]  d_kd_r, d_dd_r;

  // signed difference of the two projected radii, r cos(phi) - r0 cos(phi0), as magnitude and sign
  logic [79:0] am_nxt;
  logic        an_nxt;

  always_comb begin
    if (a_n1_r == a_n2_r) begin
      am_nxt = 80'(a_a1_r) + 80'(a_a2_r);
      an_nxt = a_n1_r;
    end else if (a_a1_r >= a_a2_r) begin
      am_nxt = 80'(a_a1_r - a_a2_r);
      an_nxt = a_n1_r;
    end else begin
      am_nxt = 80'(a_a2_r - a_a1_r);
      an_nxt = a_n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cosine results
      p_cb_r  <= cos_post(cw[0][CORDIC_STEPS-1]);
      p_cp_r  <= cos_post(cw[1][CORDIC_STEPS-1]);
      p_cp0_r <= cos_post(cw[2][CORDIC_STEPS-1]);
      p_cd_r  <= cos_post(cw[3][CORDIC_STEPS-1]);
      p_geo_r <= geo_r[CORDIC_STEPS];

      // projections and half-width partial products of the squares
      a_a1_r  <= 79'(p_geo_r.rr * mag31(p_cp_r));
      a_a2_r  <= 79'(p_geo_r.r0 * mag31(p_cp0_r));
      a_n1_r  <= p_cp_r[31];
      a_n2_r  <= !p_cp0_r[31];
      a_cbm_r <= mag31(p_cb_r);
      a_cbn_r <= p_cb_r[31];
      a_cdm_r <= mag31(p_cd_r);
      a_cdp_r <= !p_cd_r[31];
      a_rrl_r <= 72'(p_geo_r.rr * p_geo_r.rr[23:0]);
      a_rrh_r <= 72'(p_geo_r.rr * p_geo_r.rr[47:24]);
      a_r0l_r <= 72'(p_geo_r.r0 * p_geo_r.r0[23:0]);
      a_r0h_r <= 72'(p_geo_r.r0 * p_geo_r.r0[47:24]);
      a_rxl_r <= 72'(p_geo_r.rr * p_geo_r.r0[23:0]);
      a_rxh_r <= 72'(p_geo_r.rr * p_geo_r.r0[47:24]);
      a_ddl_r <= 72'(p_geo_r.dd * p_geo_r.dd[23:0]);
      a_ddh_r <= 72'(p_geo_r.dd * p_geo_r.dd[47:24]);
      a_kd_r  <= p_geo_r.kd;
      a_dd_r  <= p_geo_r.dd;

      b_am_r   <= am_nxt;
      b_xneg_r <= an_nxt != a_cbn_r;
      b_cbm_r  <= a_cbm_r;
      b_cdm_r  <= a_cdm_r;
      b_cdp_r  <= a_cdp_r;
      b_rr2_r  <= 96'(a_rrl_r) + (96'(a_rrh_r) << 24);
      b_r02_r  <= 96'(a_r0l_r) + (96'(a_r0h_r) << 24);
      b_rx_r   <= 96'(a_rxl_r) + (96'(a_rxh_r) << 24);
      b_dd2_r  <= 96'(a_ddl_r) + (96'(a_ddh_r) << 24);
      b_kd_r   <= a_kd_r;
      b_dd_r   <= a_dd_r;

      // xi numerator and the cross term of eta, split in halves
      c_xl_r   <= 71'(b_am_r[39:0] * b_cbm_r);
      c_xh_r   <= 71'(b_am_r[79:40] * b_cbm_r);
      c_s1_r   <= (128'(b_rr2_r) + 128'(b_r02_r)) << 30;
      c_pl_r   <= 80'(b_rx_r[47:0] * {b_cdm_r, 1'b0});
      c_ph_r   <= 80'(b_rx_r[95:48] * {b_cdm_r, 1'b0});
      c_xneg_r <= b_xneg_r;
      c_cdp_r  <= b_cdp_r;
      c_dd2_r  <= b_dd2_r;
      c_kd_r   <= b_kd_r;
      c_dd_r   <= b_dd_r;

      d_xnum_r <= 128'(c_xl_r) + (128'(c_xh_r) << 40);
      d_p2_r   <= 128'(c_pl_r) + (128'(c_ph_r) << 48);
      d_s1_r   <= c_s1_r;
      d_xneg_r <= c_xneg_r;
      d_cdp_r  <= c_cdp_r;
      d_dd2_r  <= c_dd2_r;
      d_kd_r   <= c_kd_r;
      d_dd_r   <= c_dd_r;
    end
  end

  // -------------------------------------------------------------- divisions
  // xi = num / D over 128 steps, eta = num * 2^30 / D^2 over 158 steps
  div_t        dx0_r, de0_r;
  div_t        xw [XDIV_STEPS];
  div_t        ew [EDIV_STEPS];
  dside_t      sd_r [EDIV_STEPS+1];
  logic [95:0] lag_r [XLAG];
  logic [95:0] xm_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      dx0_r <= '{num: d_xnum_r, rem: '0, quo: '0, ovf: 1'b0, den: 96'(d_dd_r)};
      de0_r <= '{num: (d_cdp_r ? d_s1_r - d_p2_r : d_s1_r + d_p2_r),
                 rem: '0, quo: '0, ovf: 1'b0, den: d_dd2_r};
      sd_r[0] <= '{kd: d_kd_r, xneg: d_xneg_r, zero: (d_dd_r == 48'd0)};
      for (int i = 1; i <= EDIV_STEPS; i++) sd_r[i] <= sd_r[i-1];
      // xi waits here for the longer eta chain
      lag_r[0] <= xm_fin;
      for (int i = 1; i < XLAG; i++) lag_r[i] <= lag_r[i-1];
    end
  end

  for (genvar i = 0; i < XDIV_STEPS; i++) begin : g_xdiv
    if (i == 0) begin : g_head
      fpk_div_cell u_cell (.clk(clk), .en(en), .d_in(dx0_r), .d_out(xw[i]));
    end else begin : g_body
      fpk_div_cell u_cell (.clk(clk), .en(en), .d_in(xw[i-1]), .d_out(xw[i]));
    end
  end

  for (genvar i = 0; i < EDIV_STEPS; i++) begin : g_ediv
    if (i == 0) begin : g_head
      fpk_div_cell u_cell (.clk(clk), .en(en), .d_in(de0_r), .d_out(ew[i]));
    end else begin : g_body
      fpk_div_cell u_cell (.clk(clk), .en(en), .d_in(ew[i-1]), .d_out(ew[i]));
    end
  end

  // saturate the quotients at their caps
  logic [98:0] em;
  logic [98:0] base;
  logic [98:0] tx;
  logic [98:0] sv;
  logic        neg_err;
  logic [95:0] xm;

  always_comb begin
    xm_fin = (xw[XDIV_STEPS-1].ovf || xw[XDIV_STEPS-1].quo > XI_CAP) ?
             XI_CAP[95:0] : xw[XDIV_STEPS-1].quo[95:0];
    em     = (ew[EDIV_STEPS-1].ovf || ew[EDIV_STEPS-1].quo > ETA_CAP) ?
             ETA_CAP : ew[EDIV_STEPS-1].quo;
    xm     = lag_r[XLAG-1];
    base   = em + (99'd1 << 60);
    tx     = {2'b00, xm, 1'b0};
    // root argument 1 + eta - 2 xi in q60
    neg_err = !sd_r[EDIV_STEPS].xneg && (tx > base);
    sv      = sd_r[EDIV_STEPS].xneg ? base + tx : base - tx;
  end

  // ------------------------------------------------------------ square root
  sqrt_t  sq0_r;
  sqrt_t  sw [SQRT_STEPS];
  sside_t sf_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r   <= '{v: (128'(sv) << 20), rem: '0, root: '0};
      sf_r[0] <= '{kd: sd_r[EDIV_STEPS].kd, xneg: sd_r[EDIV_STEPS].xneg,
                   err: sd_r[EDIV_STEPS].zero | neg_err, x40: xm[95:20]};
      for (int i = 1; i <= SQRT_STEPS; i++) sf_r[i] <= sf_r[i-1];
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    if (i == 0) begin : g_head
      fpk_sqrt_cell u_cell (.clk(clk), .en(en), .d_in(sq0_r), .d_out(sw[i]));
    end else begin : g_body
      fpk_sqrt_cell u_cell (.clk(clk), .en(en), .d_in(sw[i-1]), .d_out(sw[i]));
    end
  end

  // ---------------------------------------------------------- phase product
  // T = sqrt + xi - 1 in q40, as magnitude and sign
  logic [76:0] pos;
  logic [76:0] neg;
  sside_t      ss;

  always_comb begin
    ss  = sf_r[SQRT_STEPS];
    pos = 77'(sw[SQRT_STEPS-1].root) + (ss.xneg ? 77'd0 : 77'(ss.x40));
    neg = (77'd1 << 40) + (ss.xneg ? 77'(ss.x40) : 77'd0);
  end

  logic [76:0]  h_tm_r;
  logic         h_tneg_r, h_err_r;
  logic [47:0]  h_kd_r;
  logic [86:0]  i_pl_r;
  logic [85:0]  i_ph_r;
  logic         i_tneg_r, i_err_r;
  logic [124:0] j_prod_r;
  logic         j_tneg_r, j_err_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_tm_r   <= (pos >= neg) ? pos - neg : neg - pos;
      h_tneg_r <= pos < neg;
      h_err_r  <= ss.err;
      h_kd_r   <= ss.kd;

      i_pl_r   <= 87'(h_tm_r[38:0] * h_kd_r);
      i_ph_r   <= 86'(h_tm_r[76:39] * h_kd_r);
      i_tneg_r <= h_tneg_r;
      i_err_r  <= h_err_r;

      j_prod_r <= 125'(i_pl_r) + (125'(i_ph_r) << 39);
      j_tneg_r <= i_tneg_r;
      j_err_r  <= i_err_r;
    end
  end

  // round q48 to q32 half away from zero, apply sign, saturate
  logic [125:0] rnd;
  logic         sat;
  res_t         res;

  always_comb begin
    rnd = (126'(j_prod_r) + 126'd32768) >> 16;
    sat = |rnd[125:63];
    res.err = j_err_r;
    if (j_err_r) res.phase = '0;
    else if (sat) res.phase = j_tneg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else if (j_tneg_r) res.phase = 64'(-{1'b0, rnd[62:0]});
    else res.phase = {1'b0, rnd[62:0]};
  end

  // ---------------------------------------------------------- output buffer
  res_t ob_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        ob_r[cnt_r[0]] <= res;
      end
      2'b01: begin
        ob_r[0] <= ob_r[1];
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          ob_r[0] <= res;
        end else begin
          ob_r[0] <= ob_r[1];
          ob_r[1] <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid   = (cnt_r != 2'd0);
  assign out_tdata    = ob_r[0].phase;
  assign out_tuser[0] = ob_r[0].err;

endmodule

// ===== sv/fpk_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpk_cordic_cell: one rotation step of the cosine chain
// rotates x, y toward the residual angle z by atan(2^-shift)
// ----------------------------------------------------------------------------
module fpk_cordic_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [fpk_pkg::SHIFT_W-1:0] shift,
  input  logic [63:0]              atan,
  input  fpk_pkg::cordic_t         d_in,
  output fpk_pkg::cordic_t         d_out
);
  import fpk_pkg::*;

  cordic_t d_r;
  cordic_t d_nxt;
  logic signed [63:0] dx;
  logic signed [63:0] dy;

  always_comb begin
    dx    = d_in.y >>> shift;
    dy    = d_in.x >>> shift;
    d_nxt = d_in;
    if (!d_in.z[63]) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - signed'(atan);
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + signed'(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== sv/fpk_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpk_div_cell: one restoring division step
// brings down one numerator bit, subtracts the divisor when it fits
// ----------------------------------------------------------------------------
module fpk_div_cell (
  input  logic          clk,
  input  logic          en,
  input  fpk_pkg::div_t d_in,
  output fpk_pkg::div_t d_out
);
  import fpk_pkg::*;

  div_t d_r;
  div_t d_nxt;
  logic [96:0] rem_sh;
  logic [96:0] diff;
  logic        fits;

  always_comb begin
    rem_sh = {d_in.rem, d_in.num[127]};
    diff   = rem_sh - {1'b0, d_in.den};
    fits   = rem_sh >= {1'b0, d_in.den};
    d_nxt      = d_in;
    d_nxt.num  = {d_in.num[126:0], 1'b0};
    d_nxt.rem  = fits ? diff[95:0] : rem_sh[95:0];
    d_nxt.quo  = {d_in.quo[97:0], fits};
    // sticky once a quotient bit falls off the top
    d_nxt.ovf  = d_in.ovf | d_in.quo[98];
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== sv/fpk_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpk_sqrt_cell: one digit step of the integer square root
// takes two radicand bits and decides one root bit
// ----------------------------------------------------------------------------
module fpk_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  fpk_pkg::sqrt_t d_in,
  output fpk_pkg::sqrt_t d_out
);
  import fpk_pkg::*;

  sqrt_t d_r;
  sqrt_t d_nxt;
  logic [67:0] rem_sh;
  logic [67:0] trial;
  logic [67:0] diff;
  logic        fits;

  always_comb begin
    rem_sh = {d_in.rem, d_in.v[127:126]};
    trial  = {2'b00, d_in.root, 2'b01};
    diff   = rem_sh - trial;
    fits   = rem_sh >= trial;
    d_nxt      = d_in;
    d_nxt.v    = {d_in.v[125:0], 2'b00};
    d_nxt.rem  = fits ? diff[65:0] : rem_sh[65:0];
    d_nxt.root = {d_in.root[62:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== sim/tb_fresnel_phase_kernel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fresnel_phase_kernel_top: self-checking bench of the fresnel phase kernel
// geometry points go in on the input stream; an in-bench fixed-point model
// predicts phase and domain flag for each, compared in order on the output
// ----------------------------------------------------------------------------
module tb_fresnel_phase_kernel_top;
  import fpk_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;

  // field order matches in_tdata, last member lands in the low bits
  typedef struct packed {
    logic [47:0] distance;
    logic [31:0] opening_angle;
    logic [31:0] ref_azimuth;
    logic [31:0] azimuth;
    logic [47:0] ref_radius;
    logic [47:0] radius;
    logic [47:0] wave_distance;
  } geom_t;

  typedef struct packed {
    logic [63:0] phase;
    logic        domain_error;
  } psi_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0]       out_tuser;

  psi_t        psi_queue[$];
  logic [63:0] atan_tab[0:63];
  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          domain_count = 0;
  int          sat_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  fresnel_phase_kernel_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // arctangent table in q61, built from the truncated taylor series in q63
  initial begin
    logic [63:0] acc;
    int unsigned pw;
    for (int i = 0; i < 64; i++) begin
      acc = '0;
      for (int k = 0; k < 64; k++) begin
        pw = i * (2 * k + 1);
        if (pw <= 63) begin
          if (k % 2 == 0) acc = acc + ((64'd1 << 63) >> pw) / (2 * k + 1);
          else acc = acc - ((64'd1 << 63) >> pw) / (2 * k + 1);
        end
      end
      atan_tab[i] = (i == 0) ? 64'h1921_FB54_442D_1846 : (acc + 64'd2) >> 2;
    end
  end

  // cosine of a turn fraction in q30, clamped to [-1, 1]
  function automatic logic signed [63:0] cos_turn(input logic [31:0] a);
    logic [1:0]         quad;
    logic [31:0]        resid;
    logic signed [63:0] x, y, z, dx, dy, c;
    quad  = 2'((a + 32'h2000_0000) >> 30);
    resid = a - {quad, 30'd0};
    z = $signed({{32{resid[31]}}, resid}) * 64'sd3373259426;
    x = 64'sd2608131496 <<< 30;
    y = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - $signed(atan_tab[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + $signed(atan_tab[i]);
      end
    end
    case (quad)
      2'd0:    c = x;
      2'd1:    c = -y;
      2'd2:    c = -x;
      default: c = y;
    endcase
    c = (c + 64'sd2147483648) >>> 32;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    if (c < -64'sd1073741824) c = -64'sd1073741824;
    return c;
  endfunction

  function automatic logic [63:0] abs_q30(input logic signed [63:0] c);
    return c[63] ? -c : c;
  endfunction

  function automatic psi_t fresnel_psi(input geom_t g);
    psi_t               res;
    logic signed [63:0] cb, cp, cp0, cd;
    logic [127:0]       a1, a2, am, xm, em, nn, s1, p2, base, tx, sv, wv;
    logic [127:0]       pos, neg, tm, prod;
    logic [255:0]       q;
    logic [63:0]        root, cand;
    logic               n1, n2, an, xneg, tneg;
    res = '0;
    if (g.distance == 0) begin
      res.domain_error = 1'b1;
      return res;
    end
    cb  = cos_turn(g.opening_angle);
    cp  = cos_turn(g.azimuth);
    cp0 = cos_turn(g.ref_azimuth);
    cd  = cos_turn(g.azimuth - g.ref_azimuth);

    // xi magnitude and sign, r cos(phi) - r0 cos(phi0) as sign/magnitude
    a1 = {80'd0, g.radius} * {64'd0, abs_q30(cp)};
    a2 = {80'd0, g.ref_radius} * {64'd0, abs_q30(cp0)};
    n1 = cp < 0;
    n2 = !(cp0 < 0);
    if (n1 == n2) begin
      am = a1 + a2; an = n1;
    end else if (a1 >= a2) begin
      am = a1 - a2; an = n1;
    end else begin
      am = a2 - a1; an = n2;
    end
    xneg = an != (cb < 0);
    am = am * {64'd0, abs_q30(cb)};
    q  = {128'd0, am} / {208'd0, g.distance};
    xm = (q > (256'd1 << 95)) ? (128'd1 << 95) : q[127:0];

    // eta, numerator scaled by 2^30 then by 2^30 again in the division
    s1 = ({80'd0, g.radius} * g.radius + {80'd0, g.ref_radius} * g.ref_radius) << 30;
    p2 = {80'd0, g.radius} * g.ref_radius;
    p2 = p2 * {63'd0, abs_q30(cd), 1'b0};
    nn = (cd >= 0) ? s1 - p2 : s1 + p2;
    q  = ({128'd0, nn} << 30) / ({208'd0, g.distance} * g.distance);
    em = (q > (256'd1 << 97)) ? (128'd1 << 97) : q[127:0];

    base = em + (128'd1 << 60);
    tx   = xm << 1;
    if (xneg) sv = base + tx;
    else if (tx > base) begin
      res.domain_error = 1'b1;
      return res;
    end else sv = base - tx;

    // bitwise floor square root, result in q40
    wv   = sv << 20;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * cand <= wv) root = cand;
    end

    pos = {64'd0, root};
    neg = 128'd1 << 40;
    if (xneg) neg = neg + (xm >> 20);
    else pos = pos + (xm >> 20);
    tneg = pos < neg;
    tm   = tneg ? neg - pos : pos - neg;

    // round half away from zero to q32, then saturate by sign
    prod = tm * {80'd0, g.wave_distance};
    prod = (prod + 128'd32768) >> 16;
    if (prod >= (128'd1 << 63)) res.phase = tneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else res.phase = tneg ? -prod[63:0] : prod[63:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] km(input int unsigned lo, input int unsigned hi);
    return 48'({$urandom_range(hi, lo), $urandom()} >> 16);  // integer km plus random fraction
  endfunction

  // mostly plausible occultation geometry, some raw noise and near-tangent points
  function automatic geom_t pick_point();
    geom_t g;
    int    sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      g = {rnd48(), $urandom(), $urandom(), $urandom(), rnd48(), rnd48(), rnd48()};
      if ($urandom_range(3) == 0) g.distance = 48'($urandom_range(255));
    end else begin
      g.wave_distance = rnd48() >> $urandom_range(16, 0);
      g.radius        = km(70000, 150000);
      g.ref_radius    = ($urandom_range(1) == 1) ? g.radius + 48'($urandom_range(65535) << 8)
                                                 : km(70000, 150000);
      g.azimuth       = $urandom();
      g.ref_azimuth   = g.azimuth + 32'($signed($urandom_range(2000000)) - 1000000);
      g.opening_angle = $urandom();
      g.distance      = km(100000, 400000);
      if (sel < 30) begin
        // distance about equal to the ring radius, root argument near zero
        g.ref_radius  = 48'($urandom_range(3));
        g.azimuth     = 32'($signed($urandom_range(64)) - 32);
        g.opening_angle = 32'($signed($urandom_range(64)) - 32);
        g.distance    = g.radius + 48'($signed($urandom_range(8)) - 4);
      end
    end
    return g;
  endfunction

  // sender, one geometry point, held until the block takes it
  task automatic send_point(input geom_t g);
    logic go;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= g;
    forever begin
      @(negedge clk);
      go = in_tready;
      @(posedge clk);
      if (go) break;
    end
    psi_queue.push_back(fresnel_psi(g));
    sent_count++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (psi_queue.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_corners();
    geom_t g;
    geom_t base_pt;
    base_pt = '0;
    base_pt.wave_distance = 48'h0000_1000_0000;
    base_pt.radius        = 48'd100000 << 16;
    base_pt.ref_radius    = 48'd100010 << 16;
    base_pt.distance      = 48'd250000 << 16;
    // zero distance, with everything else at max and at zero
    g = '1; g.distance = '0; send_point(g);
    g = '0; send_point(g);
    // zero kD on a valid point
    g = base_pt; g.wave_distance = '0; send_point(g);
    // every field at its maximum
    g = '1; send_point(g);
    // smallest distance, huge radius: saturating xi and eta, both phase signs
    g = '0; g.wave_distance = '1; g.radius = '1; g.distance = 48'd1; send_point(g);
    g.opening_angle = 32'h8000_0000; send_point(g);
    // azimuth at each eighth turn, opening angle one below it, ref azimuth just below one eighth
    for (int qd = 0; qd < 8; qd++) begin
      g = base_pt;
      g.azimuth       = 32'(qd) << 29;
      g.ref_azimuth   = 32'h2000_0000 - 32'(qd);
      g.opening_angle = (32'(qd) << 29) - 32'd1;
      send_point(g);
    end
    // root argument at or just past zero: D within 2 of r, no reference radius
    for (int d = -2; d <= 2; d++) begin
      g = '0;
      g.wave_distance = 48'hFFFF_FFFF_FFFF;
      g.radius        = 48'd200000 << 16;
      g.distance      = g.radius + 48'(d);
      send_point(g);
    end
    // lowest nonzero values
    g = '0; g.wave_distance = 48'd1; g.radius = 48'd1; g.ref_radius = 48'd1;
    g.distance = 48'd1; send_point(g);
    drain();
  endtask

  task automatic test_random(input int n, input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < n; i++) send_point(pick_point());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // receiver, result checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    psi_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (psi_queue.size() == 0) begin
        $error("unexpected result: phase %h domain_error %0d", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = psi_queue.pop_front();
        checked_count++;
        if (want.domain_error) domain_count++;
        if (want.phase == 64'h7FFF_FFFF_FFFF_FFFF || want.phase == 64'h8000_0000_0000_0000)
          sat_count++;
        if (out_tdata !== want.phase) begin
          $error("phase: expected %h, got %h", want.phase, out_tdata);
          err_count++;
        end
        if (out_tuser[0] !== want.domain_error) begin
          $error("domain_error: expected %0d, got %0d", want.domain_error, out_tuser[0]);
          err_count++;
        end
      end
    end
  end

  // counts cycles with work outstanding but no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (!in_tvalid && psi_queue.size() == 0)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_fresnel_phase_kernel_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_random(145, 0, 0);
    test_random(145, 62, 0);
    test_random(145, 0, 62);
    test_random(145, 13, 13);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (psi_queue.size() != 0) begin
      $error("%0d results never arrived", psi_queue.size());
      err_count++;
    end
    $display("sent %0d points, checked %0d results (%0d domain errors, %0d saturated)",
             sent_count, checked_count, domain_count, sat_count);
    $display("phases: corners, free flow, sender gaps, receiver stalls, mixed");
    if (err_count == 0) $display("tb_fresnel_phase_kernel_top: clean");
    else $display("tb_fresnel_phase_kernel_top: errors");
    $finish;
  end

endmodule

// ===== fresnel_phase_kernel_top.f =====
sv/fpk_pkg.sv
sv/fpk_cordic_cell.sv
sv/fpk_div_cell.sv
sv/fpk_sqrt_cell.sv
sv/fresnel_phase_kernel_top.sv
sim/tb_fresnel_phase_kernel_top.sv
